// ----- rtl/core/stt_pkg.sv -----
`default_nettype none

package stt_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int ROW_BITS_DEF    = 8;
  localparam int FLAT_LIMIT_DEF  = 8;
  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int FIFO_DEPTH_DEF  = 4;

  localparam int ROW_W  = 11;
  localparam int COL_W  = 10;
  localparam int NC_W   = 11;
  localparam int CFG_W  = 11;
  localparam int MODE_W = 2;
  localparam int SUM_W  = 13;
  localparam int OUT_W  = 32;
  localparam int APB_DW = 32;
  localparam int APB_AW = 4;

  typedef logic signed [ROW_W-1:0] row_t;

  localparam row_t ROW_MAX = 11'sd1023;
  localparam row_t ROW_MIN = -11'sd1024;
  localparam logic signed [SUM_W-1:0] SUM_ROW_MAX = 13'sd1023;
  localparam logic signed [SUM_W-1:0] SUM_ROW_MIN = -13'sd1024;

  localparam logic [MODE_W-1:0] MODE_FREE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RAMP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MIN  = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  localparam logic [CFG_W-1:0]  RST_WIDTH  = 11'd320;
  localparam logic [CFG_W-1:0]  RST_HEIGHT = 11'd240;
  localparam logic [MODE_W-1:0] RST_MODE   = MODE_RAMP;
  localparam row_t              RST_LAST_ROW = row_t'(RST_HEIGHT >> 1);

  typedef struct packed {
    logic [CFG_W-1:0]  width;
    logic [CFG_W-1:0]  height;
    logic [MODE_W-1:0] mode;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    row_t             row;
  } entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/stt_ram.sv -----
`default_nettype none

module stt_ram #(
  parameter int WIDTH = stt_pkg::ROW_W,
  parameter int DEPTH = stt_pkg::MAX_COLUMNS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read and a write to one address return the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/stt_front.sv -----
`default_nettype none

module stt_front #(
  parameter int SAMPLE_BITS = stt_pkg::SAMPLE_BITS_DEF,
  parameter int ROW_BITS    = stt_pkg::ROW_BITS_DEF,
  parameter int FLAT_LIMIT  = stt_pkg::FLAT_LIMIT_DEF,
  parameter int MAX_COLUMNS = stt_pkg::MAX_COLUMNS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire stt_pkg::cfg_t          cfg,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire logic                   buffer_start,
  input  wire logic                   fifo_full,
  output logic                        push,
  output stt_pkg::entry_t             push_entry
);

  localparam int HALF_ROW  = 2 ** (ROW_BITS - 1);
  localparam int FLAT_BITS = $clog2(FLAT_LIMIT + 1);

  logic [ROW_BITS-1:0]              scaled;
  logic signed [stt_pkg::SUM_W-1:0] raw_row;
  stt_pkg::row_t                    y;
  logic [stt_pkg::CFG_W-1:0]        eff_width;
  logic                             trig;
  logic                             accept;
  logic                             emit;
  logic                             go;
  logic                             restart;
  logic [stt_pkg::NC_W-1:0]         col_x;

  logic [stt_pkg::NC_W-1:0] next_col_r,  next_col_nxt;
  stt_pkg::row_t            last_row_r,  last_row_nxt;
  logic                     armed_r,     armed_nxt;
  logic [FLAT_BITS-1:0]     flat_r,      flat_nxt;
  stt_pkg::row_t            run_peak_r,  run_peak_nxt;
  stt_pkg::row_t            prev_peak_r, prev_peak_nxt;

  generate
    if (SAMPLE_BITS >= ROW_BITS) begin : g_down
      assign scaled = ROW_BITS'(sample >> (SAMPLE_BITS - ROW_BITS));
    end else begin : g_up
      assign scaled = ROW_BITS'(sample) << (ROW_BITS - SAMPLE_BITS);
    end
  endgenerate

  always_comb begin
    raw_row = $signed(stt_pkg::SUM_W'(cfg.height >> 1))
            + $signed(stt_pkg::SUM_W'(HALF_ROW))
            - $signed(stt_pkg::SUM_W'(scaled));
    if (raw_row > stt_pkg::SUM_ROW_MAX) begin
      y = stt_pkg::ROW_MAX;
    end else if (raw_row < stt_pkg::SUM_ROW_MIN) begin
      y = stt_pkg::ROW_MIN;
    end else begin
      y = stt_pkg::row_t'(raw_row);
    end
  end

  assign eff_width = (cfg.width > stt_pkg::CFG_W'(MAX_COLUMNS)) ?
                     stt_pkg::CFG_W'(MAX_COLUMNS) : cfg.width;
  assign trig      = (cfg.mode == stt_pkg::MODE_RAMP) || (cfg.mode == stt_pkg::MODE_MIN);
  assign in_tready = !fifo_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    prev_peak_nxt = prev_peak_r;
    run_peak_nxt  = run_peak_r;
    armed_nxt     = armed_r;
    flat_nxt      = flat_r;
    last_row_nxt  = last_row_r;
    next_col_nxt  = next_col_r;
    go            = 1'b1;
    restart       = 1'b0;
    emit          = 1'b0;

    if (buffer_start) begin
      prev_peak_nxt = run_peak_r;
      run_peak_nxt  = '0;
      armed_nxt     = 1'b0;
      flat_nxt      = '0;
    end
    if (y > run_peak_nxt) begin
      run_peak_nxt = y;
    end

    if (next_col_r >= eff_width) begin
      restart = 1'b1;
      if (trig) begin
        if (cfg.mode == stt_pkg::MODE_MIN && !armed_nxt && y >= prev_peak_nxt) begin
          armed_nxt = 1'b1;
        end
        if (y == last_row_r) begin
          flat_nxt = flat_nxt + FLAT_BITS'(1);
          if (flat_nxt < FLAT_BITS'(FLAT_LIMIT)) begin
            go = 1'b0;
          end else begin
            flat_nxt = '0;
          end
        end else if (y > last_row_r) begin
          last_row_nxt = y;
          flat_nxt     = '0;
          if (cfg.mode == stt_pkg::MODE_RAMP) begin
            armed_nxt = 1'b1;
          end
          go = 1'b0;
        end else begin
          last_row_nxt = y;
          flat_nxt     = '0;
          if (!armed_nxt) begin
            go = 1'b0;
          end
        end
        if (go) begin
          armed_nxt = 1'b0;
        end
      end
    end

    col_x = restart ? '0 : next_col_r;
    if (go && col_x < stt_pkg::NC_W'(MAX_COLUMNS)) begin
      emit         = 1'b1;
      next_col_nxt = col_x + stt_pkg::NC_W'(1);
      if (trig) begin
        last_row_nxt = y;
      end
    end else if (go) begin
      next_col_nxt = col_x;
    end
  end

  assign push           = accept && emit;
  assign push_entry.col = col_x[stt_pkg::COL_W-1:0];
  assign push_entry.row = y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_col_r  <= '0;
      last_row_r  <= stt_pkg::RST_LAST_ROW;
      armed_r     <= 1'b0;
      flat_r      <= '0;
      run_peak_r  <= '0;
      prev_peak_r <= '0;
    end else if (accept) begin
      next_col_r  <= next_col_nxt;
      last_row_r  <= last_row_nxt;
      armed_r     <= armed_nxt;
      flat_r      <= flat_nxt;
      run_peak_r  <= run_peak_nxt;
      prev_peak_r <= prev_peak_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/stt_fifo.sv -----
`default_nettype none

module stt_fifo #(
  parameter int DEPTH = stt_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire stt_pkg::entry_t push_entry,
  output logic                 full,
  input  wire logic            pop,
  output stt_pkg::entry_t      head,
  output logic                 not_empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  stt_pkg::entry_t  slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slots[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue read while empty");

endmodule

`default_nettype wire

// ----- rtl/core/stt_back.sv -----
`default_nettype none

module stt_back #(
  parameter int MAX_COLUMNS = stt_pkg::MAX_COLUMNS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        not_empty,
  input  wire stt_pkg::entry_t             head,
  output logic                             pop,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [stt_pkg::OUT_W-1:0]        out_tdata
);

  localparam int AW = $clog2(MAX_COLUMNS);

  logic [stt_pkg::NC_W-1:0]  head_col;
  logic                      hit;
  logic [stt_pkg::ROW_W-1:0] ram_q;
  stt_pkg::row_t             erase;

  logic [stt_pkg::NC_W-1:0]  fill_r, fill_nxt;
  logic                      out_valid_r;
  logic                      hit_r;
  logic [stt_pkg::COL_W-1:0] col_r;
  stt_pkg::row_t             draw_r;

  assign head_col = stt_pkg::NC_W'(head.col);
  assign pop      = not_empty && (!out_valid_r || out_tready);
  // columns are written in order from 0, so the written set is a prefix
  assign hit      = head_col < fill_r;
  assign fill_nxt = (pop && head_col == fill_r) ? fill_r + stt_pkg::NC_W'(1) : fill_r;

  stt_ram #(
    .WIDTH (stt_pkg::ROW_W),
    .DEPTH (MAX_COLUMNS)
  ) u_trace (
    .clk     (clk),
    .we      (pop),
    .waddr   (head.col[AW-1:0]),
    .wdata   (head.row),
    .re      (pop),
    .raddr   (head.col[AW-1:0]),
    .rdata_r (ram_q)
  );

  assign erase      = hit_r ? stt_pkg::row_t'(ram_q) : '0;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {draw_r, erase, col_r};

  always_ff @(posedge clk) begin
    if (pop) begin
      col_r  <= head.col;
      draw_r <= head.row;
      hit_r  <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= stt_pkg::NC_W'(MAX_COLUMNS))
    else $error("fill count past store depth");

  a_col_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_col <= fill_r)
    else $error("column skips past written prefix");

  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_tvalid)
    else $error("popped word not presented");

endmodule

`default_nettype wire

// ----- rtl/core/scope_trigger_trace_core.sv -----
`default_nettype none
// A word taken on in_* passes the queue and the output register before out_* offers it.
// Throughput: one word per cycle unless the queue is full; one store read and write a cycle.
// Words taken while waiting for a trigger give no output word.
// Reset (rst_n, synchronous): sweep, trigger state and queue cleared, registers to defaults.
// Trace store has no clearing pass: a fill count makes unwritten columns read as zero.

module scope_trigger_trace_core #(
  parameter int SAMPLE_BITS = stt_pkg::SAMPLE_BITS_DEF,
  parameter int ROW_BITS    = stt_pkg::ROW_BITS_DEF,
  parameter int FLAT_LIMIT  = stt_pkg::FLAT_LIMIT_DEF,
  parameter int MAX_COLUMNS = stt_pkg::MAX_COLUMNS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  input  wire logic [((SAMPLE_BITS + 7) / 8)*8-1:0]  in_tdata,   // sample
  input  wire logic                                  in_tuser,   // buffer_start
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  output logic [stt_pkg::OUT_W-1:0]                  out_tdata,  // column, erase_row, draw_row
  input  wire logic                                  cfg_psel,
  input  wire logic                                  cfg_penable,
  input  wire logic                                  cfg_pwrite,
  input  wire logic [stt_pkg::APB_AW-1:0]            cfg_paddr,
  input  wire logic [stt_pkg::APB_DW-1:0]            cfg_pwdata,
  output logic [stt_pkg::APB_DW-1:0]                 cfg_prdata,
  output logic                                       cfg_pready
);

  stt_pkg::cfg_t   cfg_r;
  logic            cfg_wr;
  logic [1:0]      reg_idx;
  logic            fifo_full;
  logic            push;
  stt_pkg::entry_t push_entry;
  logic            pop;
  stt_pkg::entry_t head;
  logic            not_empty;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= stt_pkg::RST_WIDTH;
      cfg_r.height <= stt_pkg::RST_HEIGHT;
      cfg_r.mode   <= stt_pkg::RST_MODE;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        stt_pkg::REG_WIDTH:  cfg_r.width  <= cfg_pwdata[stt_pkg::CFG_W-1:0];
        stt_pkg::REG_HEIGHT: cfg_r.height <= cfg_pwdata[stt_pkg::CFG_W-1:0];
        stt_pkg::REG_MODE:   cfg_r.mode   <= cfg_pwdata[stt_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      stt_pkg::REG_WIDTH:  cfg_prdata = stt_pkg::APB_DW'(cfg_r.width);
      stt_pkg::REG_HEIGHT: cfg_prdata = stt_pkg::APB_DW'(cfg_r.height);
      stt_pkg::REG_MODE:   cfg_prdata = stt_pkg::APB_DW'(cfg_r.mode);
      default:             cfg_prdata = '0;
    endcase
  end

  stt_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ROW_BITS    (ROW_BITS),
    .FLAT_LIMIT  (FLAT_LIMIT),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .sample       (in_tdata[SAMPLE_BITS-1:0]),
    .buffer_start (in_tuser),
    .fifo_full    (fifo_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  stt_fifo #(
    .DEPTH (stt_pkg::FIFO_DEPTH_DEF)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (fifo_full),
    .pop        (pop),
    .head       (head),
    .not_empty  (not_empty)
  );

  stt_back #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .not_empty  (not_empty),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// ----- tb/trace_pixel_checker.sv -----
`timescale 1ns / 100ps

module trace_pixel_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  input  wire logic                        in_tready,
  input  wire logic [15:0]                 in_tdata,   // sample
  input  wire logic                        in_tuser,   // buffer_start
  input  wire logic                        out_tvalid,
  input  wire logic                        out_tready,
  input  wire logic [stt_pkg::OUT_W-1:0]   out_tdata,  // column, erase_row, draw_row
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [stt_pkg::APB_AW-1:0]  cfg_paddr,
  input  wire logic [stt_pkg::APB_DW-1:0]  cfg_pwdata,
  input  wire logic [stt_pkg::APB_DW-1:0]  cfg_prdata,
  input  wire logic                        cfg_pready,
  output int                               fail_count,
  output int                               pending,
  output int                               words_seen
);
  import stt_pkg::*;

  localparam logic [APB_AW-1:0] ADDR_WIDTH  = {REG_WIDTH, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_HEIGHT = {REG_HEIGHT, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_MODE   = {REG_MODE, 2'b00};
  localparam int MAX_PRINTED = 100;

  typedef struct {
    logic [COL_W-1:0] column;
    row_t             erase;
    row_t             draw;
  } pixel_t;

  logic [CFG_W-1:0]  sweep_width;
  logic [CFG_W-1:0]  sweep_height;
  logic [MODE_W-1:0] trig_mode;

  logic [NC_W-1:0] cur_col;
  row_t            trace_mem [MAX_COLUMNS_DEF];
  row_t            last_row;
  bit              armed;
  logic [3:0]      flat_run;
  row_t            peak_now;
  row_t            peak_prev;

  pixel_t pixels_due [$];

  task automatic report_mismatch(string msg);
    fail_count++;
    if (fail_count <= MAX_PRINTED)
      $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic clear_trace();
    sweep_width  = RST_WIDTH;
    sweep_height = RST_HEIGHT;
    trig_mode    = RST_MODE;
    cur_col      = '0;
    for (int i = 0; i < MAX_COLUMNS_DEF; i++)
      trace_mem[i] = '0;
    last_row  = RST_LAST_ROW;
    armed     = 1'b0;
    flat_run  = '0;
    peak_now  = '0;
    peak_prev = '0;
    pixels_due.delete();
  endtask

  // one sample through the sweep and trigger logic
  task automatic advance_trace(logic [11:0] smp, logic buf_start);
    int     y;
    int     span;
    bit     trig;
    bit     fire;
    row_t   yr;
    logic [NC_W-1:0] x;
    pixel_t px;
    y = int'(sweep_height >> 1) + (1 << ROW_BITS_DEF) / 2 - int'(smp[11:4]);
    if (y > 1023) y = 1023;
    if (y < -1024) y = -1024;
    yr   = row_t'(y);
    trig = (trig_mode == MODE_RAMP) || (trig_mode == MODE_MIN);
    span = (sweep_width > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : int'(sweep_width);
    if (buf_start) begin
      peak_prev = peak_now;
      peak_now  = '0;
      armed     = 1'b0;
      flat_run  = '0;
    end
    if (yr > peak_now) peak_now = yr;
    fire = 1'b1;
    if (int'(cur_col) >= span) begin
      if (trig) begin
        if (trig_mode == MODE_MIN && !armed && yr >= peak_prev) armed = 1'b1;
        if (yr == last_row) begin
          flat_run++;
          if (flat_run < FLAT_LIMIT_DEF) fire = 1'b0;
          else flat_run = '0;
        end else if (yr > last_row) begin
          last_row = yr;
          flat_run = '0;
          if (trig_mode == MODE_RAMP) armed = 1'b1;
          fire = 1'b0;
        end else begin
          last_row = yr;
          flat_run = '0;
          if (!armed) fire = 1'b0;
        end
        if (fire) armed = 1'b0;
      end
      if (fire) cur_col = '0;
    end
    if (fire) begin
      x = cur_col;
      if (x < MAX_COLUMNS_DEF) begin
        px.column = x[COL_W-1:0];
        px.erase  = trace_mem[x[COL_W-1:0]];
        px.draw   = yr;
        pixels_due.push_back(px);
        trace_mem[x[COL_W-1:0]] = yr;
        cur_col = x + 1'b1;
        if (trig) last_row = yr;
      end
    end
  endtask

  always @(posedge clk) begin
    pixel_t          want;
    logic [COL_W-1:0] got_col;
    row_t            got_erase;
    row_t            got_draw;
    logic [APB_DW-1:0] reg_val;
    if (!rst_n) begin
      clear_trace();
      fail_count = 0;
      words_seen = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          case (cfg_paddr)
            ADDR_WIDTH:  sweep_width  = cfg_pwdata[CFG_W-1:0];
            ADDR_HEIGHT: sweep_height = cfg_pwdata[CFG_W-1:0];
            ADDR_MODE:   trig_mode    = cfg_pwdata[MODE_W-1:0];
            default: ;
          endcase
        end else begin
          case (cfg_paddr)
            ADDR_WIDTH:  reg_val = APB_DW'(sweep_width);
            ADDR_HEIGHT: reg_val = APB_DW'(sweep_height);
            default:     reg_val = APB_DW'(trig_mode);
          endcase
          if (cfg_prdata !== reg_val)
            report_mismatch($sformatf("register at %0d reads %0d, want %0d",
                                      cfg_paddr, cfg_prdata, reg_val));
        end
      end
      if (out_tvalid && out_tready) begin
        words_seen++;
        got_col   = out_tdata[COL_W-1:0];
        got_erase = row_t'(out_tdata[COL_W+ROW_W-1:COL_W]);
        got_draw  = row_t'(out_tdata[COL_W+2*ROW_W-1:COL_W+ROW_W]);
        if (pixels_due.size() == 0) begin
          report_mismatch($sformatf("unexpected word col %0d erase %0d draw %0d",
                                    got_col, got_erase, got_draw));
        end else begin
          want = pixels_due.pop_front();
          if (got_col !== want.column)
            report_mismatch($sformatf("column %0d, want %0d", got_col, want.column));
          if (got_erase !== want.erase)
            report_mismatch($sformatf("erase_row %0d, want %0d at col %0d",
                                      got_erase, want.erase, want.column));
          if (got_draw !== want.draw)
            report_mismatch($sformatf("draw_row %0d, want %0d at col %0d",
                                      got_draw, want.draw, want.column));
        end
      end
      if (in_tvalid && in_tready)
        advance_trace(in_tdata[11:0], in_tuser);
    end
    pending = pixels_due.size();
  end

endmodule

// ----- tb/scope_trigger_trace_core_tb.sv -----
`timescale 1ns / 100ps

module scope_trigger_trace_core_tb;
  import stt_pkg::*;

  localparam logic [APB_AW-1:0] ADDR_WIDTH  = {REG_WIDTH, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_HEIGHT = {REG_HEIGHT, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_MODE   = {REG_MODE, 2'b00};
  localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SQUEEZE_AT  = 60;
  localparam int HOLD_OFF    = 300;
  localparam int SETTLE      = 8;
  localparam int N_PHASES    = 7;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [15:0] in_tdata;   // sample
  logic in_tuser;          // buffer_start
  logic out_tvalid;
  logic out_tready;
  logic [OUT_W-1:0] out_tdata;  // column, erase_row, draw_row
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic cfg_pready;

  int fail_count;
  int pending;
  int words_seen;
  int sent_total;
  int settings_used;
  int walk;
  int hold_left;
  bit steady;
  bit squeezed;
  int unsigned cycle_count = 0;

  scope_trigger_trace_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  trace_pixel_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready),
    .fail_count(fail_count), .pending(pending), .words_seen(words_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  task automatic offer_sample(logic [11:0] smp, logic buf_start);
    int g;
    g = steady ? 0 : pick_gap();
    repeat (g) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, smp};
    in_tuser  <= buf_start;
    do @(posedge clk); while (!in_tready);
    sent_total++;
  endtask

  // random walk with flat runs, jumps and rail values
  task automatic offer_random();
    int r;
    int nxt;
    logic [11:0] smp;
    if (hold_left > 0) begin
      hold_left--;
      smp = {walk[11:4], 4'($urandom)};
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        nxt = walk + int'($urandom_range(0, 400)) - 200;
        if (nxt < 0) nxt = 0;
        if (nxt > 4095) nxt = 4095;
        walk = nxt;
      end else if (r < 75) begin
        hold_left = $urandom_range(6, 11);
      end else if (r < 90) begin
        walk = int'($urandom_range(0, 4095));
      end else begin
        walk = $urandom_range(0, 1) ? 4095 : 0;
      end
      smp = 12'(walk);
    end
    offer_sample(smp, $urandom_range(0, 15) == 0);
  endtask

  task automatic apb_access(bit wr, logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic read_back();
    apb_access(1'b0, ADDR_WIDTH, '0);
    apb_access(1'b0, ADDR_HEIGHT, '0);
    apb_access(1'b0, ADDR_MODE, '0);
  endtask

  task automatic apply_setting(int w, int h, logic [MODE_W-1:0] m);
    settle();
    apb_access(1'b1, ADDR_WIDTH, APB_DW'(w));
    apb_access(1'b1, ADDR_HEIGHT, APB_DW'(h));
    apb_access(1'b1, ADDR_MODE, APB_DW'(m));
    read_back();
    settings_used++;
  endtask

  // receiver: random ready pattern, one long hold-off once the stream is flowing
  initial begin
    int run;
    int k;
    out_tready = 1'b0;
    forever begin
      if (!squeezed && sent_total >= SQUEEZE_AT) begin
        squeezed = 1'b1;
        for (k = 0; k < HOLD_OFF; k++) begin
          @(negedge clk);
          out_tready <= 1'b0;
        end
      end
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 25);
      for (k = 0; k < run; k++) begin
        @(negedge clk);
        out_tready <= 1'b1;
      end
      k = $urandom_range(0, 9);
      run = (k < 5) ? 0 : (k < 9) ? $urandom_range(1, 3) : $urandom_range(15, 45);
      for (k = 0; k < run; k++) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
    end
  end

  initial begin
    int ph_w [N_PHASES] = '{1024, 5, 1, 17, 40, 8, 12};
    int ph_h [N_PHASES] = '{1024, 240, 1024, 2047, 0, 512, 1023};
    logic [MODE_W-1:0] ph_m [N_PHASES] = '{MODE_FREE, MODE_RAMP, MODE_MIN, MODE_RAMP,
                                           MODE_MIN, MODE_SPARE, MODE_RAMP};
    int ph_n [N_PHASES] = '{300, 60, 60, 50, 50, 40, 50};
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    sent_total  = 0;
    settings_used = 0;
    walk      = 2048;
    hold_left = 0;
    steady    = 1'b0;
    squeezed  = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    read_back();

    // saturated rows, flat-run forced trigger, then a ramp trigger
    apply_setting(2, 2047, MODE_RAMP);
    offer_sample(12'h000, 1'b1);
    offer_sample(12'hFFF, 1'b0);
    repeat (9) offer_sample(12'h000, 1'b0);
    offer_sample(12'hFFF, 1'b0);
    offer_sample(12'hFFF, 1'b0);
    offer_sample(12'h000, 1'b0);
    offer_sample(12'hFFF, 1'b0);

    // zero width, spare mode
    apply_setting(0, 1, MODE_SPARE);
    offer_sample(12'h00F, 1'b0);
    offer_sample(12'hFF0, 1'b1);
    offer_sample(12'h800, 1'b0);

    // width over the column limit, zero height, min-value mode
    apply_setting(2047, 0, MODE_MIN);
    offer_sample(12'h7FF, 1'b1);
    offer_sample(12'h000, 1'b0);
    offer_sample(12'hFFF, 1'b1);
    offer_sample(12'h0F0, 1'b0);

    for (int p = 0; p < N_PHASES; p++) begin
      apply_setting(ph_w[p], ph_h[p], ph_m[p]);
      steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < ph_n[p]; i++)
        offer_random();
    end
    steady = 1'b0;

    settle();
    repeat (4 * SETTLE) @(posedge clk);

    $display("%0d samples sent over %0d settings, %0d pixel words checked",
             sent_total, settings_used, words_seen);
    $display("widths 0..2047, heights 0..2047, all four trigger modes, one long output stall");
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d words outstanding", fail_count, pending);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/stt_pkg.sv
rtl/core/stt_ram.sv
rtl/core/stt_front.sv
rtl/core/stt_fifo.sv
rtl/core/stt_back.sv
rtl/core/scope_trigger_trace_core.sv
tb/trace_pixel_checker.sv
tb/scope_trigger_trace_core_tb.sv
